>>> design/sdcp_pkg.sv
package sdcp_pkg;

  localparam int RING_DEPTH_DEF = 64;

  // port offsets from the card base
  localparam logic [3:0] OFS_MIX_INDEX  = 4'd4;
  localparam logic [3:0] OFS_MIX_DATA   = 4'd5;
  localparam logic [3:0] OFS_RESET      = 4'd6;
  localparam logic [3:0] OFS_READ_DATA  = 4'd10;
  localparam logic [3:0] OFS_WRITE_DATA = 4'd12;
  localparam logic [3:0] OFS_STATUS_A   = 4'd14;
  localparam logic [3:0] OFS_STATUS_B   = 4'd15;

  // mixer register indexes
  localparam logic [7:0] MIX_IDX_MASTER = 8'h22;
  localparam logic [7:0] MIX_IDX_3F     = 8'h3F;
  localparam logic [7:0] MIX_IDX_IGNORE = 8'h83;

  // DSP opcodes
  localparam logic [7:0] OP_NONE        = 8'h00;
  localparam logic [7:0] OP_SET_RATE    = 8'h41;
  localparam logic [7:0] OP_DMA16_START = 8'hB4;
  localparam logic [23:0] DMA16_PARAMS  = 24'h30FF0F;

  localparam logic [7:0] REPLY_RESET     = 8'hAA;
  localparam logic [7:0] WR_STATUS_BYTE  = 8'h7F;
  localparam logic [7:0] RD_STATUS_BYTE  = 8'hFF;
  localparam logic [7:0] MIX_VOL_DEFAULT = 8'hFF;

  // command field
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic err;
    logic dma;
  } cmd_res_t;

  // number of parameter bytes that follow each opcode
  function automatic logic [1:0] param_len(input logic [7:0] op);
    logic [1:0] n;
    n = 2'd0;
    case (op)
      8'h04, 8'h08, 8'h0F, 8'h10, 8'h38, 8'h40,
      8'hE0, 8'hE2, 8'hE4, 8'hF9:                 n = 2'd1;
      8'h05, 8'h0E, 8'h14, 8'h15, 8'h16, 8'h17,
      8'h24, 8'h41, 8'h42, 8'h48,
      8'h74, 8'h75, 8'h76, 8'h77, 8'h80:          n = 2'd2;
      default: begin
        if (op[7:4] == 4'hB || op[7:4] == 4'hC) n = 2'd3;
      end
    endcase
    return n;
  endfunction

endpackage

>>> design/sdcp_if.sv
interface sdcp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [3:0] port_offset;
  logic [7:0] write_byte;

  modport source (output valid, command, port_offset, write_byte, input ready);
  modport sink   (input valid, command, port_offset, write_byte, output ready);
endinterface

interface sdcp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_byte;
  logic        access_status;
  logic        dma_start;
  logic [15:0] sample_rate;

  modport source (output valid, read_byte, access_status, dma_start, sample_rate,
                  input ready);
  modport sink   (input valid, read_byte, access_status, dma_start, sample_rate,
                  output ready);
endinterface

>>> design/sdcp_cmd.sv
module sdcp_cmd (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              strobe,
  input  logic [7:0]        byte_in,
  output sdcp_pkg::cmd_res_t res,
  output logic [15:0]       rate
);

  logic [7:0]  pend_r, pend_nxt;
  logic [1:0]  rem_r, rem_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [15:0] rate_r, rate_nxt;
  logic [7:0]  op_w;
  logic [1:0]  rem_w;
  logic [23:0] acc_w;

  always_comb begin
    op_w     = pend_r;
    rem_w    = rem_r;
    acc_w    = acc_r;
    pend_nxt = pend_r;
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    rate_nxt = rate_r;
    res      = '0;
    if (strobe) begin
      if (pend_r == sdcp_pkg::OP_NONE) begin
        op_w  = byte_in;
        rem_w = sdcp_pkg::param_len(byte_in);
        acc_w = '0;
      end else if (rem_r != 2'd0) begin
        acc_w = {acc_r[15:0], byte_in};
        rem_w = rem_r - 2'd1;
      end
      pend_nxt = op_w;
      rem_nxt  = rem_w;
      acc_nxt  = acc_w;
      if (rem_w == 2'd0) begin
        if (op_w == sdcp_pkg::OP_SET_RATE) begin
          rate_nxt = acc_w[15:0];
        end else if (op_w == sdcp_pkg::OP_DMA16_START && acc_w == sdcp_pkg::DMA16_PARAMS) begin
          res.dma = 1'b1;
        end else begin
          res.err = 1'b1;
        end
        pend_nxt = sdcp_pkg::OP_NONE;
        acc_nxt  = '0;
      end
    end
  end

  assign rate = rate_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= sdcp_pkg::OP_NONE;
      rem_r  <= 2'd0;
      acc_r  <= '0;
      rate_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      rem_r  <= rem_nxt;
      acc_r  <= acc_nxt;
      rate_r <= rate_nxt;
    end
  end

  // a half-built command always has its opcode held
  a_rem_has_op: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r != 2'd0 |-> pend_r != sdcp_pkg::OP_NONE)
    else $error("parameter bytes pending without opcode");

  a_dma_err_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.dma && res.err))
    else $error("dma start and error together");

  a_rate_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !strobe |=> rate_r == $past(rate_r))
    else $error("sample rate changed without a command byte");

endmodule

>>> design/sound_dsp_command_port.sv
// Sound-card DSP command port.
// in_ch carries one byte-wide bus access per item: command (0 read, 1 write),
// port_offset from the card base and write_byte. out_ch returns one item per
// access: read_byte, access_status (1 = unsupported port, mixer index or
// opcode), a one-item dma_start pulse for an accepted 16-bit DMA playback
// command, and sample_rate as it stands after the access.
// Each access passes an input register, then the decode and state update
// feeding the result register. One access is taken per cycle for as long as
// the result side keeps up; a stalled result register holds the input register,
// and in_ch.ready drops only when both are full.
// Reset (rst_n low, synchronous) empties the reply ring, clears the command
// assembler and sample rate, sets both mixer volumes to 0xFF and drops both
// valids. The reply ring only ever holds the reset reply 0xAA, so it is kept as
// a pair of pointers; a write pointer that laps the read pointer empties it.
module sound_dsp_command_port #(
  parameter int RING_DEPTH = sdcp_pkg::RING_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  sdcp_in_if.sink         in_ch,
  sdcp_out_if.source      out_ch
);

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // input register
  logic       in_vld_r;
  logic       in_cmd_r;
  logic [3:0] in_ofs_r;
  logic [7:0] in_byte_r;

  // result register
  logic        out_vld_r;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_err_r, out_err_nxt;
  logic        out_dma_r;
  logic [15:0] out_rate_r;

  // block state
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [7:0]    last_r, last_nxt;
  logic [7:0]    mix_sel_r, mix_sel_nxt;
  logic [7:0]    vol_r, vol_nxt;
  logic [7:0]    mix3f_r, mix3f_nxt;

  logic adv, go, cmd_strobe;
  sdcp_pkg::cmd_res_t cmd_res;
  logic [15:0] rate;

  assign adv         = !out_vld_r || out_ch.ready;
  assign go          = in_vld_r && adv;
  assign in_ch.ready = !in_vld_r || adv;
  assign cmd_strobe  = go && in_cmd_r == sdcp_pkg::CMD_WRITE &&
                       in_ofs_r == sdcp_pkg::OFS_WRITE_DATA;

  sdcp_cmd u_cmd (
    .clk     (clk),
    .rst_n   (rst_n),
    .strobe  (cmd_strobe),
    .byte_in (in_byte_r),
    .res     (cmd_res),
    .rate    (rate)
  );

  always_comb begin
    wr_ptr_nxt   = wr_ptr_r;
    rd_ptr_nxt   = rd_ptr_r;
    last_nxt     = last_r;
    mix_sel_nxt  = mix_sel_r;
    vol_nxt      = vol_r;
    mix3f_nxt    = mix3f_r;
    out_byte_nxt = '0;
    out_err_nxt  = 1'b0;
    if (in_cmd_r == sdcp_pkg::CMD_WRITE) begin
      case (in_ofs_r)
        sdcp_pkg::OFS_MIX_INDEX: mix_sel_nxt = in_byte_r;
        sdcp_pkg::OFS_MIX_DATA: begin
          if (mix_sel_r == sdcp_pkg::MIX_IDX_MASTER)   vol_nxt = in_byte_r;
          else if (mix_sel_r == sdcp_pkg::MIX_IDX_3F)  mix3f_nxt = in_byte_r;
          else if (mix_sel_r != sdcp_pkg::MIX_IDX_IGNORE) out_err_nxt = 1'b1;
        end
        sdcp_pkg::OFS_RESET: begin
          wr_ptr_nxt = (wr_ptr_r == PW'(RING_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
        end
        sdcp_pkg::OFS_WRITE_DATA: out_err_nxt = cmd_res.err;
        default: out_err_nxt = 1'b1;
      endcase
    end else begin
      case (in_ofs_r)
        sdcp_pkg::OFS_MIX_INDEX: out_byte_nxt = mix_sel_r;
        sdcp_pkg::OFS_MIX_DATA: begin
          if (mix_sel_r == sdcp_pkg::MIX_IDX_MASTER)  out_byte_nxt = vol_r;
          else if (mix_sel_r == sdcp_pkg::MIX_IDX_3F) out_byte_nxt = mix3f_r;
          else out_err_nxt = 1'b1;
        end
        sdcp_pkg::OFS_READ_DATA: begin
          // empty ring repeats the last reply
          if (rd_ptr_r != wr_ptr_r) begin
            last_nxt   = sdcp_pkg::REPLY_RESET;
            rd_ptr_nxt = (rd_ptr_r == PW'(RING_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
          end
          out_byte_nxt = last_nxt;
        end
        sdcp_pkg::OFS_WRITE_DATA: out_byte_nxt = sdcp_pkg::WR_STATUS_BYTE;
        sdcp_pkg::OFS_STATUS_A,
        sdcp_pkg::OFS_STATUS_B:   out_byte_nxt = sdcp_pkg::RD_STATUS_BYTE;
        default: out_err_nxt = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      last_r    <= '0;
      mix_sel_r <= '0;
      vol_r     <= sdcp_pkg::MIX_VOL_DEFAULT;
      mix3f_r   <= sdcp_pkg::MIX_VOL_DEFAULT;
    end else begin
      if (in_ch.ready) in_vld_r <= in_ch.valid;
      if (adv)         out_vld_r <= in_vld_r;
      if (go) begin
        wr_ptr_r  <= wr_ptr_nxt;
        rd_ptr_r  <= rd_ptr_nxt;
        last_r    <= last_nxt;
        mix_sel_r <= mix_sel_nxt;
        vol_r     <= vol_nxt;
        mix3f_r   <= mix3f_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_cmd_r  <= in_ch.command;
      in_ofs_r  <= in_ch.port_offset;
      in_byte_r <= in_ch.write_byte;
    end
    if (go) begin
      out_byte_r <= out_byte_nxt;
      out_err_r  <= out_err_nxt;
      out_dma_r  <= cmd_res.dma;
      out_rate_r <= rate;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.read_byte     = out_byte_r;
  assign out_ch.access_status = out_err_r;
  assign out_ch.dma_start     = out_dma_r;
  assign out_ch.sample_rate   = out_rate_r;

  a_dma_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_dma_r |-> !out_err_r)
    else $error("dma start reported with error status");

  a_write_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    go && in_cmd_r == sdcp_pkg::CMD_WRITE |=> out_byte_r == 8'h00)
    else $error("write item returned data");

  a_pop_reply: assert property (@(posedge clk) disable iff (!rst_n)
    go && in_cmd_r == sdcp_pkg::CMD_READ && in_ofs_r == sdcp_pkg::OFS_READ_DATA &&
    rd_ptr_r != wr_ptr_r |=> last_r == sdcp_pkg::REPLY_RESET)
    else $error("ring pop did not return the reset reply");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !go |=> $stable(rd_ptr_r) && $stable(wr_ptr_r) && $stable(mix_sel_r))
    else $error("state changed without an item");

endmodule

>>> tb/sound_dsp_command_port_test.sv
module sound_dsp_command_port_test;

  localparam int RING_N      = sdcp_pkg::RING_DEPTH_DEF;
  localparam int STUCK_LIMIT = 2000;
  localparam int TAIL_ITEMS  = 150;
  localparam int RANDOM_ITEMS = 1200;

  typedef struct {
    logic       cmd;
    logic [3:0] ofs;
    logic [7:0] wbyte;
  } bus_access_t;

  typedef struct {
    logic [7:0]  rbyte;
    logic        status;
    logic        dma;
    logic [15:0] rate;
  } bus_reply_t;

  logic clk = 1'b0;
  logic rst_n;

  sdcp_in_if  in_ch();
  sdcp_out_if out_ch();

  sound_dsp_command_port dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [7:0]  ring_mem [RING_N];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;
  logic [7:0]  last_pop = 8'h00;
  logic [7:0]  mix_sel = 8'h00;
  logic [7:0]  vol_master = sdcp_pkg::MIX_VOL_DEFAULT;
  logic [7:0]  vol_3f = sdcp_pkg::MIX_VOL_DEFAULT;
  logic [7:0]  op_pending = sdcp_pkg::OP_NONE;
  int unsigned args_left = 0;
  logic [23:0] arg_acc = 24'h0;
  logic [15:0] rate_now = 16'h0;

  bus_access_t accesses_to_send[$];
  bus_reply_t  replies_due[$];

  int mismatches = 0;
  int accesses_done = 0;
  int replies_seen = 0;
  int dma_pulses = 0;
  int rate_writes = 0;
  int rejected = 0;
  int ring_laps = 0;
  int gap_left = 0;
  int quiet_left = 0;
  int stall_left = 0;
  int hush_left = 0;
  int stuck_cycles = 0;
  logic tail_run = 1'b0;

  // parameter bytes following each opcode
  function automatic int opcode_arg_bytes(input logic [7:0] op);
    case (op)
      8'h04, 8'h08, 8'h0F, 8'h10, 8'h38, 8'h40, 8'hE0, 8'hE2, 8'hE4, 8'hF9: return 1;
      8'h05, 8'h0E, 8'h14, 8'h15, 8'h16, 8'h17, 8'h24, 8'h41, 8'h42, 8'h48,
      8'h74, 8'h75, 8'h76, 8'h77, 8'h80: return 2;
      default: return (op >= 8'hB0 && op <= 8'hCF) ? 3 : 0;
    endcase
  endfunction

  function automatic bus_reply_t predict_reply(input bus_access_t a);
    bus_reply_t r;
    r.rbyte = 8'h00;
    r.status = 1'b0;
    r.dma = 1'b0;
    if (a.cmd == sdcp_pkg::CMD_WRITE) begin
      case (a.ofs)
        sdcp_pkg::OFS_MIX_INDEX: mix_sel = a.wbyte;
        sdcp_pkg::OFS_MIX_DATA: begin
          if (mix_sel == sdcp_pkg::MIX_IDX_MASTER) vol_master = a.wbyte;
          else if (mix_sel == sdcp_pkg::MIX_IDX_3F) vol_3f = a.wbyte;
          else if (mix_sel != sdcp_pkg::MIX_IDX_IGNORE) r.status = 1'b1;
        end
        sdcp_pkg::OFS_RESET: begin
          ring_mem[wr_ptr] = sdcp_pkg::REPLY_RESET;
          wr_ptr = (wr_ptr + 1) % RING_N;
          // write pointer caught the read pointer: ring looks empty again
          if (wr_ptr == rd_ptr) ring_laps++;
        end
        sdcp_pkg::OFS_WRITE_DATA: begin
          if (op_pending == sdcp_pkg::OP_NONE) begin
            op_pending = a.wbyte;
            args_left = opcode_arg_bytes(a.wbyte);
            arg_acc = 24'h0;
          end else if (args_left != 0) begin
            arg_acc = {arg_acc[15:0], a.wbyte};
            args_left--;
          end
          if (args_left == 0) begin
            if (op_pending == sdcp_pkg::OP_SET_RATE) begin
              rate_now = arg_acc[15:0];
              rate_writes++;
            end else if (op_pending == sdcp_pkg::OP_DMA16_START &&
                         arg_acc == sdcp_pkg::DMA16_PARAMS) begin
              r.dma = 1'b1;
            end else begin
              r.status = 1'b1;
            end
            op_pending = sdcp_pkg::OP_NONE;
            arg_acc = 24'h0;
          end
        end
        default: r.status = 1'b1;
      endcase
    end else begin
      case (a.ofs)
        sdcp_pkg::OFS_MIX_INDEX: r.rbyte = mix_sel;
        sdcp_pkg::OFS_MIX_DATA: begin
          if (mix_sel == sdcp_pkg::MIX_IDX_MASTER) r.rbyte = vol_master;
          else if (mix_sel == sdcp_pkg::MIX_IDX_3F) r.rbyte = vol_3f;
          else r.status = 1'b1;
        end
        sdcp_pkg::OFS_READ_DATA: begin
          if (rd_ptr != wr_ptr) begin
            last_pop = ring_mem[rd_ptr];
            rd_ptr = (rd_ptr + 1) % RING_N;
          end
          r.rbyte = last_pop;
        end
        sdcp_pkg::OFS_WRITE_DATA: r.rbyte = sdcp_pkg::WR_STATUS_BYTE;
        sdcp_pkg::OFS_STATUS_A, sdcp_pkg::OFS_STATUS_B: r.rbyte = sdcp_pkg::RD_STATUS_BYTE;
        default: r.status = 1'b1;
      endcase
    end
    if (r.status) rejected++;
    r.rate = rate_now;
    return r;
  endfunction

  task automatic log_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", replies_seen, what, got, want);
    mismatches++;
  endtask

  task automatic queue_access(input logic cmd, input logic [3:0] ofs, input logic [7:0] b);
    bus_access_t a;
    a.cmd = cmd;
    a.ofs = ofs;
    a.wbyte = b;
    accesses_to_send.push_back(a);
  endtask

  task automatic queue_dsp_byte(input logic [7:0] b);
    queue_access(sdcp_pkg::CMD_WRITE, sdcp_pkg::OFS_WRITE_DATA, b);
  endtask

  task automatic add_random_sequence();
    int roll;
    int n;
    int k;
    logic [7:0] op;
    logic [23:0] args;
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      // long run of resets that can make the write pointer lap the read pointer
      n = $urandom_range(60, 70);
      for (k = 0; k < n; k++)
        queue_access(sdcp_pkg::CMD_WRITE, sdcp_pkg::OFS_RESET, 8'($urandom_range(0, 255)));
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++)
        queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_READ_DATA, 8'($urandom_range(0, 255)));
    end else if (roll < 20) begin
      queue_dsp_byte(sdcp_pkg::OP_SET_RATE);
      case ($urandom_range(0, 3))
        0: args = 24'h0;
        1: args = 24'hFFFF;
        default: args = 24'($urandom_range(0, 65535));
      endcase
      queue_dsp_byte(args[15:8]);
      // sometimes broken off early
      if ($urandom_range(0, 9) != 0) queue_dsp_byte(args[7:0]);
    end else if (roll < 38) begin
      queue_dsp_byte(sdcp_pkg::OP_DMA16_START);
      args = sdcp_pkg::DMA16_PARAMS;
      if ($urandom_range(0, 3) == 0) args = args ^ (24'h1 << $urandom_range(0, 23));
      if ($urandom_range(0, 9) == 0) args = 24'($urandom_range(0, 24'hFFFFFF));
      queue_dsp_byte(args[23:16]);
      queue_dsp_byte(args[15:8]);
      if ($urandom_range(0, 9) != 0) queue_dsp_byte(args[7:0]);
    end else if (roll < 50) begin
      op = 8'($urandom_range(0, 255));
      queue_dsp_byte(op);
      n = opcode_arg_bytes(op);
      for (k = 0; k < n; k++) queue_dsp_byte(8'($urandom_range(0, 255)));
    end else if (roll < 65) begin
      case ($urandom_range(0, 4))
        0: op = sdcp_pkg::MIX_IDX_MASTER;
        1: op = sdcp_pkg::MIX_IDX_3F;
        2: op = sdcp_pkg::MIX_IDX_IGNORE;
        default: op = 8'($urandom_range(0, 255));
      endcase
      queue_access(sdcp_pkg::CMD_WRITE, sdcp_pkg::OFS_MIX_INDEX, op);
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(0, 2))
          0: queue_access(sdcp_pkg::CMD_WRITE, sdcp_pkg::OFS_MIX_DATA,
                          8'($urandom_range(0, 255)));
          1: queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_MIX_DATA,
                          8'($urandom_range(0, 255)));
          default: queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_MIX_INDEX,
                                8'($urandom_range(0, 255)));
        endcase
      end
    end else if (roll < 78) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++)
        queue_access(sdcp_pkg::CMD_WRITE, sdcp_pkg::OFS_RESET, 8'($urandom_range(0, 255)));
      n = $urandom_range(1, 6);
      for (k = 0; k < n; k++)
        queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_READ_DATA, 8'($urandom_range(0, 255)));
    end else if (roll < 88) begin
      case ($urandom_range(0, 3))
        0: queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_WRITE_DATA,
                        8'($urandom_range(0, 255)));
        1: queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_STATUS_A,
                        8'($urandom_range(0, 255)));
        2: queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_STATUS_B,
                        8'($urandom_range(0, 255)));
        default: queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_MIX_INDEX,
                              8'($urandom_range(0, 255)));
      endcase
    end else begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++)
        queue_access(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                     8'($urandom_range(0, 255)));
    end
  endtask

  // driver
  always @(posedge clk) begin : drive_bus
    bus_access_t nxt;
    bus_access_t taken;
    int roll;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.command <= sdcp_pkg::CMD_READ;
      in_ch.port_offset <= 4'h0;
      in_ch.write_byte <= 8'h00;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        taken.cmd = in_ch.command;
        taken.ofs = in_ch.port_offset;
        taken.wbyte = in_ch.write_byte;
        replies_due.push_back(predict_reply(taken));
        accesses_done++;
      end
      tail_run <= accesses_to_send.size() < TAIL_ITEMS;
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0 && !tail_run) begin
          gap_left <= gap_left - 1;
          in_ch.valid <= 1'b0;
        end else if (accesses_to_send.size() != 0) begin
          nxt = accesses_to_send.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.command <= nxt.cmd;
          in_ch.port_offset <= nxt.ofs;
          in_ch.write_byte <= nxt.wbyte;
          if (quiet_left != 0) begin
            quiet_left <= quiet_left - 1;
          end else begin
            roll = $urandom_range(0, 99);
            if (roll < 15) gap_left <= $urandom_range(1, 14);
            else if (roll < 18) quiet_left <= $urandom_range(30, 120);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin : check_bus
    bus_reply_t want;
    logic ready_next;
    int roll;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        replies_seen++;
        if (replies_due.size() == 0) begin
          log_mismatch("item with none outstanding", 16'(out_ch.read_byte), 16'h0);
        end else begin
          want = replies_due.pop_front();
          if (out_ch.read_byte !== want.rbyte)
            log_mismatch("read_byte", 16'(out_ch.read_byte), 16'(want.rbyte));
          if (out_ch.access_status !== want.status)
            log_mismatch("access_status", 16'(out_ch.access_status), 16'(want.status));
          if (out_ch.dma_start !== want.dma)
            log_mismatch("dma_start", 16'(out_ch.dma_start), 16'(want.dma));
          if (out_ch.sample_rate !== want.rate)
            log_mismatch("sample_rate", out_ch.sample_rate, want.rate);
          if (want.dma) dma_pulses++;
        end
      end
      ready_next = 1'b1;
      if (stall_left != 0 && !tail_run) begin
        stall_left <= stall_left - 1;
        ready_next = 1'b0;
      end else if (hush_left != 0) begin
        hush_left <= hush_left - 1;
      end else if (!tail_run) begin
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
          stall_left <= $urandom_range(0, 13);
          ready_next = 1'b0;
        end else if (roll < 15) begin
          hush_left <= $urandom_range(30, 120);
        end
      end
      out_ch.ready <= ready_next;
    end
  end

  // watchdog: cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                 stuck_cycles, replies_due.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    int k;
    int directed;
    for (k = 0; k < RING_N; k++) ring_mem[k] = 8'h00;
    rst_n = 1'b0;

    // empty ring repeats last reply (0 after reset), then one reset reply
    queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_READ_DATA, 8'h00);
    queue_access(sdcp_pkg::CMD_WRITE, sdcp_pkg::OFS_RESET, 8'hFF);
    queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_READ_DATA, 8'h00);
    queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_READ_DATA, 8'hFF);
    queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_WRITE_DATA, 8'h00);
    queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_STATUS_A, 8'h00);
    // mixer: index readback, unknown index, volume regs, ignored index
    queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_MIX_INDEX, 8'h00);
    queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_MIX_DATA, 8'h00);
    queue_access(sdcp_pkg::CMD_WRITE, sdcp_pkg::OFS_MIX_INDEX, sdcp_pkg::MIX_IDX_MASTER);
    queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_MIX_DATA, 8'h00);
    queue_access(sdcp_pkg::CMD_WRITE, sdcp_pkg::OFS_MIX_DATA, 8'h00);
    queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_MIX_DATA, 8'h00);
    queue_access(sdcp_pkg::CMD_WRITE, sdcp_pkg::OFS_MIX_INDEX, sdcp_pkg::MIX_IDX_3F);
    queue_access(sdcp_pkg::CMD_READ, sdcp_pkg::OFS_MIX_DATA, 8'h00);
    queue_access(sdcp_pkg::CMD_WRITE, sdcp_pkg::OFS_MIX_INDEX, sdcp_pkg::MIX_IDX_IGNORE);
    queue_access(sdcp_pkg::CMD_WRITE, sdcp_pkg::OFS_MIX_DATA, 8'h12);
    queue_access(sdcp_pkg::CMD_WRITE, sdcp_pkg::OFS_MIX_INDEX, 8'hFF);
    queue_access(sdcp_pkg::CMD_WRITE, sdcp_pkg::OFS_MIX_DATA, 8'hFF);
    // rate to full scale, a good DMA start, opcode zero
    queue_dsp_byte(sdcp_pkg::OP_SET_RATE);
    queue_dsp_byte(8'hFF);
    queue_dsp_byte(8'hFF);
    queue_dsp_byte(sdcp_pkg::OP_DMA16_START);
    queue_dsp_byte(sdcp_pkg::DMA16_PARAMS[23:16]);
    queue_dsp_byte(sdcp_pkg::DMA16_PARAMS[15:8]);
    queue_dsp_byte(sdcp_pkg::DMA16_PARAMS[7:0]);
    queue_dsp_byte(sdcp_pkg::OP_NONE);
    directed = accesses_to_send.size();

    while (accesses_to_send.size() < directed + RANDOM_ITEMS) add_random_sequence();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (accesses_to_send.size() != 0 || in_ch.valid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d bus accesses sent, %0d results checked", accesses_done, replies_seen);
    $display("%0d DMA starts, %0d rate writes, %0d rejected accesses, ring lapped %0d times",
             dma_pulses, rate_writes, rejected, ring_laps);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
design/sdcp_pkg.sv
design/sdcp_if.sv
design/sdcp_cmd.sv
design/sound_dsp_command_port.sv
tb/sound_dsp_command_port_test.sv
